>>> sv/pointer_motion_acceleration_macros.svh
// ----------------------------------------------------------------------------
// pointer motion acceleration assertion macros
// shared property forms for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef POINTER_MOTION_ACCELERATION_MACROS_SVH
`define POINTER_MOTION_ACCELERATION_MACROS_SVH

// same-cycle implication
`define PMA_CHECK(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PMA_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/pma_pkg.sv
// ----------------------------------------------------------------------------
// pma_pkg
// types and fixed constants of the pointer motion acceleration block
// ----------------------------------------------------------------------------
package pma_pkg;

    typedef struct packed {
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic        [31:0] time_ms;
    } pma_in_t;

    typedef struct packed {
        logic signed [7:0] report_x;
        logic signed [7:0] report_y;
    } pma_out_t;

    typedef struct packed {
        logic [6:0]  cpi_hundreds;
        logic [23:0] accel_start_speed;
        logic [23:0] accel_end_speed;
        logic [9:0]  gain_min;
        logic [9:0]  gain_max;
        logic [15:0] idle_reset_ms;
        logic        left_side;
        logic        mounting;
    } pma_cfg_t;

    // register indexes
    localparam logic [2:0] REG_CPI   = 3'd0;
    localparam logic [2:0] REG_START = 3'd1;
    localparam logic [2:0] REG_END   = 3'd2;
    localparam logic [2:0] REG_GMIN  = 3'd3;
    localparam logic [2:0] REG_GMAX  = 3'd4;
    localparam logic [2:0] REG_IDLE  = 3'd5;
    localparam logic [2:0] REG_LEFT  = 3'd6;
    localparam logic [2:0] REG_MOUNT = 3'd7;

    localparam logic [6:0]  CPI_DEFAULT   = 7'd5;
    localparam logic [6:0]  CPI_MAX       = 7'd120;
    localparam logic [23:0] START_DEFAULT = 24'd100;
    localparam logic [23:0] END_DEFAULT   = 24'd1000;
    localparam logic [9:0]  GMIN_DEFAULT  = 10'd100;
    localparam logic [9:0]  GMAX_DEFAULT  = 10'd100;
    localparam logic [15:0] IDLE_DEFAULT  = 16'd100;

    // serial divider geometry
    localparam int DIV_NUM_W = 42;
    localparam int DIV_DEN_W = 46;
    localparam int DIV_CNT_W = 6;

    localparam logic [DIV_CNT_W-1:0] STEPS_SPEED = 6'd33;
    localparam logic [DIV_CNT_W-1:0] STEPS_T     = 6'd34;
    localparam logic [DIV_CNT_W-1:0] STEPS_S     = 6'd30;
    localparam logic [DIV_CNT_W-1:0] STEPS_G     = 6'd20;
    localparam logic [DIV_CNT_W-1:0] STEPS_AXIS  = 6'd42;

    localparam logic [16:0] SPEED_SCALE = 17'd100000;
    localparam logic [13:0] CPI_SCALE   = 14'd100;
    localparam logic [9:0]  T_SCALE     = 10'd1000;
    localparam logic [11:0] CUBE_BASE   = 12'd3000;
    localparam logic [DIV_DEN_W-1:0] S_SCALE    = 46'd1000000;
    localparam logic [DIV_DEN_W-1:0] SPAN_SCALE = 46'd1000;
    localparam logic [DIV_DEN_W-1:0] GAIN_SCALE = 46'd100;

    localparam logic [31:0] ROOT_TOP = 32'h4000_0000;

endpackage

>>> sv/pointer_motion_acceleration.sv
// ----------------------------------------------------------------------------
// pointer_motion_acceleration
// sensor delta to pointer report with speed dependent gain
// ----------------------------------------------------------------------------
//  channel   signals                          word
//  in        in_valid / in_ready / in_word    delta_x, delta_y, time_ms
//  out       out_valid / out_ready / out_word report_x, report_y
//  config    psel penable pwrite paddr ...    eight registers at 4*index
//
//  a word with no motion goes straight to the report; a moving word runs
//  the square root unit, then the bit-serial divider (one quotient bit a
//  cycle) for the speed and for each axis, and also for the gain curve when
//  the speed falls inside the gain window
//  a new word is taken once the previous one is finished; a report not yet
//  taken holds only the final step, no reset sweep is needed
// ----------------------------------------------------------------------------
`include "pointer_motion_acceleration_macros.svh"

module pointer_motion_acceleration #(
    parameter int REPORT_LIMIT      = 127,
    parameter int FIRST_INTERVAL_MS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pma_pkg::pma_in_t  in_word,
    output logic              out_valid,
    input  logic              out_ready,
    output pma_pkg::pma_out_t out_word,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int NW = pma_pkg::DIV_NUM_W;
    localparam int DW = pma_pkg::DIV_DEN_W;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_PREP   = 5'd1;
    localparam logic [4:0] S_SUM    = 5'd2;
    localparam logic [4:0] S_RTGO   = 5'd3;
    localparam logic [4:0] S_RTWAIT = 5'd4;
    localparam logic [4:0] S_SPMUL  = 5'd5;
    localparam logic [4:0] S_SPGO   = 5'd6;
    localparam logic [4:0] S_SPWAIT = 5'd7;
    localparam logic [4:0] S_GSEL   = 5'd8;
    localparam logic [4:0] S_TGO    = 5'd9;
    localparam logic [4:0] S_TWAIT  = 5'd10;
    localparam logic [4:0] S_TSQ    = 5'd11;
    localparam logic [4:0] S_TCUBE  = 5'd12;
    localparam logic [4:0] S_SGO    = 5'd13;
    localparam logic [4:0] S_SWAIT  = 5'd14;
    localparam logic [4:0] S_SPAN   = 5'd15;
    localparam logic [4:0] S_GGO    = 5'd16;
    localparam logic [4:0] S_GWAIT  = 5'd17;
    localparam logic [4:0] S_SCL    = 5'd18;
    localparam logic [4:0] S_AGO    = 5'd19;
    localparam logic [4:0] S_AWAIT  = 5'd20;
    localparam logic [4:0] S_AFIX1  = 5'd21;
    localparam logic [4:0] S_AFIX2  = 5'd22;
    localparam logic [4:0] S_OUT    = 5'd23;

    localparam logic [1:0] SGN_ZERO = 2'b00;
    localparam logic [1:0] SGN_POS  = 2'b01;
    localparam logic [1:0] SGN_NEG  = 2'b11;

    localparam logic signed [31:0] LIM32 = 32'(REPORT_LIMIT);
    localparam logic signed [15:0] LIM16 = 16'(REPORT_LIMIT);
    localparam logic [31:0]        FIRST_MS = 32'(FIRST_INTERVAL_MS);
    localparam logic signed [47:0] I32_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] I32_MIN = -48'sh0000_8000_0000;

    pma_pkg::pma_cfg_t cfg;
    logic              cpi_clear;

    logic [4:0]               state_reg;
    pma_pkg::pma_in_t         in_reg;
    logic [31:0]              last_time_reg;
    logic [31:0]              elapsed_reg;
    logic [13:0]              cpi100_reg;
    logic [30:0]              xx_reg, yy_reg;
    logic [31:0]              n_reg;
    logic [NW-1:0]            num_reg;
    logic [DW-1:0]            den_reg;
    logic [pma_pkg::DIV_CNT_W-1:0] steps_reg;
    logic [31:0]              avg_reg;
    logic [9:0]               t_reg;
    logic [19:0]              tt_reg;
    logic [11:0]              w_reg;
    logic [9:0]               s_reg;
    logic                     span_neg_reg;
    logic [9:0]               gain_reg;
    logic                     axis_reg;
    logic                     p_neg_reg;
    logic signed [47:0]       scaled_reg;
    logic signed [31:0]       whole_reg;
    logic signed [16:0]       fr_reg;
    logic signed [31:0]       frac_x_reg, frac_y_reg;
    logic [1:0]               sign_x_reg, sign_y_reg;
    logic signed [15:0]       gx_reg, gy_reg;
    logic                     out_valid_reg;
    pma_pkg::pma_out_t        out_word_reg;

    logic          div_start;
    logic          div_done;
    logic [NW-1:0] div_quot;
    logic          root_start;
    logic          root_done;
    logic [15:0]   root_val;

    // prep stage
    logic [31:0]        elapsed_c;
    logic               gap_c;
    logic [1:0]         sx_c, sy_c, lsx_c, lsy_c;
    logic               flip_c;
    logic               moving_c;
    logic signed [31:0] xx_c, yy_c;

    // gain and axis math
    logic [32:0]        spd_sum_c;
    logic [31:0]        avg_new_c;
    logic [23:0]        dspd_c;
    logic [33:0]        tnum_c;
    logic [29:0]        cube_c;
    logic signed [10:0] span_c;
    logic [9:0]         span_abs_c;
    logic [19:0]        sprod_c;
    logic signed [11:0] gain_c;
    logic signed [15:0] v_c;
    logic signed [26:0] p_c;
    logic [25:0]        p_abs_c;
    logic signed [47:0] q_c;
    logic signed [31:0] frac_sel_c;
    logic signed [47:0] abs_c;
    logic signed [31:0] whole_mag_c;
    logic signed [16:0] frac_mag_c;
    logic signed [15:0] lim_c;
    logic signed [31:0] excess_c;
    logic signed [47:0] kept_c;
    logic signed [31:0] frac_new_c;
    logic signed [15:0] rx_c, ry_c;

    pma_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .cfg       (cfg),
        .cpi_clear (cpi_clear)
    );

    pma_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .steps (steps_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    pma_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .n     (n_reg),
        .done  (root_done),
        .root  (root_val)
    );

    assign div_start  = (state_reg == S_SPGO) || (state_reg == S_TGO) ||
                        (state_reg == S_SGO) || (state_reg == S_GGO) ||
                        (state_reg == S_AGO);
    assign root_start = (state_reg == S_RTGO);

    always_comb
    begin
        if (last_time_reg == 32'd0)
            elapsed_c = FIRST_MS;
        else
            elapsed_c = in_reg.time_ms - last_time_reg;
        if (elapsed_c == 32'd0)
            elapsed_c = 32'd1;
        gap_c = elapsed_c >= {16'd0, cfg.idle_reset_ms};

        sx_c = (in_reg.delta_x < 0) ? SGN_NEG : ((in_reg.delta_x > 0) ? SGN_POS : SGN_ZERO);
        sy_c = (in_reg.delta_y < 0) ? SGN_NEG : ((in_reg.delta_y > 0) ? SGN_POS : SGN_ZERO);
        lsx_c = gap_c ? SGN_ZERO : sign_x_reg;
        lsy_c = gap_c ? SGN_ZERO : sign_y_reg;
        flip_c = (sx_c != SGN_ZERO && lsx_c != SGN_ZERO && sx_c != lsx_c) ||
                 (sy_c != SGN_ZERO && lsy_c != SGN_ZERO && sy_c != lsy_c);
        moving_c = (sx_c != SGN_ZERO) || (sy_c != SGN_ZERO);
        xx_c = in_reg.delta_x * in_reg.delta_x;
        yy_c = in_reg.delta_y * in_reg.delta_y;
    end

    always_comb
    begin
        spd_sum_c = {1'b0, avg_reg} + {1'b0, div_quot[31:0]};
        // a cleared average restarts from the new sample
        avg_new_c = (avg_reg == 32'd0) ? div_quot[31:0] : spd_sum_c[32:1];

        dspd_c = avg_reg[23:0] - cfg.accel_start_speed;
        tnum_c = dspd_c * pma_pkg::T_SCALE;
        cube_c = 30'(tt_reg * w_reg);

        span_c     = $signed({1'b0, cfg.gain_max}) - $signed({1'b0, cfg.gain_min});
        span_abs_c = span_c[10] ? 10'(-span_c) : span_c[9:0];
        sprod_c    = span_abs_c * s_reg;
        gain_c     = span_neg_reg ? $signed({2'b00, cfg.gain_min}) - $signed({2'b00, div_quot[9:0]})
                                  : $signed({2'b00, cfg.gain_min}) + $signed({2'b00, div_quot[9:0]});

        v_c     = axis_reg ? in_reg.delta_y : in_reg.delta_x;
        p_c     = v_c * $signed({1'b0, gain_reg});
        p_abs_c = p_c[26] ? 26'(-p_c) : p_c[25:0];

        frac_sel_c = axis_reg ? frac_y_reg : frac_x_reg;
        q_c = p_neg_reg ? -$signed({6'd0, div_quot}) : $signed({6'd0, div_quot});

        // truncate toward zero, remainder keeps the sign of the sum
        abs_c       = scaled_reg[47] ? -scaled_reg : scaled_reg;
        whole_mag_c = abs_c[47:16];
        frac_mag_c  = $signed({1'b0, abs_c[15:0]});

        if (whole_reg < -LIM32)
            lim_c = -LIM16;
        else if (whole_reg > LIM32)
            lim_c = LIM16;
        else
            lim_c = whole_reg[15:0];
        excess_c = whole_reg - 32'(lim_c);
        kept_c   = 48'(fr_reg) + (48'(excess_c) <<< 16);
        if (excess_c == 32'sd0)
            frac_new_c = 32'(fr_reg);
        else if (kept_c > I32_MAX)
            frac_new_c = I32_MAX[31:0];
        else if (kept_c < I32_MIN)
            frac_new_c = I32_MIN[31:0];
        else
            frac_new_c = kept_c[31:0];

        if (!cfg.mounting)
        begin
            rx_c = cfg.left_side ? -gy_reg : gy_reg;
            ry_c = cfg.left_side ? -gx_reg : gx_reg;
        end
        else
        begin
            rx_c = gx_reg;
            ry_c = -gy_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            last_time_reg <= '0;
            avg_reg       <= '0;
            frac_x_reg    <= '0;
            frac_y_reg    <= '0;
            sign_x_reg    <= SGN_ZERO;
            sign_y_reg    <= SGN_ZERO;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_PREP;
                end
                S_PREP:
                begin
                    last_time_reg <= in_reg.time_ms;
                    if (gap_c || flip_c)
                        avg_reg <= '0;
                    if (gap_c || (flip_c && sx_c != SGN_ZERO && sx_c != lsx_c))
                        frac_x_reg <= '0;
                    if (gap_c || (flip_c && sy_c != SGN_ZERO && sy_c != lsy_c))
                        frac_y_reg <= '0;
                    sign_x_reg <= (sx_c != SGN_ZERO) ? sx_c : lsx_c;
                    sign_y_reg <= (sy_c != SGN_ZERO) ? sy_c : lsy_c;
                    state_reg  <= moving_c ? S_SUM : S_OUT;
                end
                S_SUM:    state_reg <= S_RTGO;
                S_RTGO:   state_reg <= S_RTWAIT;
                S_RTWAIT:
                begin
                    if (root_done)
                        state_reg <= S_SPMUL;
                end
                S_SPMUL:  state_reg <= S_SPGO;
                S_SPGO:   state_reg <= S_SPWAIT;
                S_SPWAIT:
                begin
                    if (div_done)
                    begin
                        avg_reg   <= avg_new_c;
                        state_reg <= S_GSEL;
                    end
                end
                S_GSEL:
                begin
                    if (avg_reg <= {8'd0, cfg.accel_start_speed} ||
                        avg_reg >= {8'd0, cfg.accel_end_speed})
                        state_reg <= S_SCL;
                    else
                        state_reg <= S_TGO;
                end
                S_TGO:    state_reg <= S_TWAIT;
                S_TWAIT:
                begin
                    if (div_done)
                        state_reg <= S_TSQ;
                end
                S_TSQ:    state_reg <= S_TCUBE;
                S_TCUBE:  state_reg <= S_SGO;
                S_SGO:    state_reg <= S_SWAIT;
                S_SWAIT:
                begin
                    if (div_done)
                        state_reg <= S_SPAN;
                end
                S_SPAN:   state_reg <= S_GGO;
                S_GGO:    state_reg <= S_GWAIT;
                S_GWAIT:
                begin
                    if (div_done)
                        state_reg <= S_SCL;
                end
                S_SCL:    state_reg <= S_AGO;
                S_AGO:    state_reg <= S_AWAIT;
                S_AWAIT:
                begin
                    if (div_done)
                        state_reg <= S_AFIX1;
                end
                S_AFIX1:  state_reg <= S_AFIX2;
                S_AFIX2:
                begin
                    if (axis_reg)
                        frac_y_reg <= frac_new_c;
                    else
                        frac_x_reg <= frac_new_c;
                    state_reg <= axis_reg ? S_OUT : S_SCL;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase

            // a resolution change restarts the filter
            if (cpi_clear)
            begin
                last_time_reg <= '0;
                avg_reg       <= '0;
                frac_x_reg    <= '0;
                frac_y_reg    <= '0;
                sign_x_reg    <= SGN_ZERO;
                sign_y_reg    <= SGN_ZERO;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    in_reg <= in_word;
            end
            S_PREP:
            begin
                elapsed_reg <= elapsed_c;
                cpi100_reg  <= 14'(cfg.cpi_hundreds) * pma_pkg::CPI_SCALE;
                xx_reg      <= xx_c[30:0];
                yy_reg      <= yy_c[30:0];
                axis_reg    <= 1'b0;
                gx_reg      <= '0;
                gy_reg      <= '0;
            end
            S_SUM:
            begin
                n_reg   <= {1'b0, xx_reg} + {1'b0, yy_reg};
                den_reg <= cpi100_reg * elapsed_reg;
            end
            S_SPMUL:
            begin
                num_reg   <= {33'(root_val * pma_pkg::SPEED_SCALE), 9'd0};
                steps_reg <= pma_pkg::STEPS_SPEED;
            end
            S_GSEL:
            begin
                gain_reg  <= (avg_reg <= {8'd0, cfg.accel_start_speed}) ? cfg.gain_min
                                                                         : cfg.gain_max;
                num_reg   <= {tnum_c, 8'd0};
                den_reg   <= DW'(cfg.accel_end_speed - cfg.accel_start_speed);
                steps_reg <= pma_pkg::STEPS_T;
            end
            S_TWAIT:
            begin
                t_reg <= div_quot[9:0];
            end
            S_TSQ:
            begin
                tt_reg <= t_reg * t_reg;
                w_reg  <= pma_pkg::CUBE_BASE - {1'b0, t_reg, 1'b0};
            end
            S_TCUBE:
            begin
                num_reg   <= {cube_c, 12'd0};
                den_reg   <= pma_pkg::S_SCALE;
                steps_reg <= pma_pkg::STEPS_S;
            end
            S_SWAIT:
            begin
                s_reg <= div_quot[9:0];
            end
            S_SPAN:
            begin
                span_neg_reg <= span_c[10];
                num_reg      <= {sprod_c, 22'd0};
                den_reg      <= pma_pkg::SPAN_SCALE;
                steps_reg    <= pma_pkg::STEPS_G;
            end
            S_GWAIT:
            begin
                gain_reg <= gain_c[9:0];
            end
            S_SCL:
            begin
                p_neg_reg <= p_c[26];
                num_reg   <= {p_abs_c, 16'd0};
                den_reg   <= pma_pkg::GAIN_SCALE;
                steps_reg <= pma_pkg::STEPS_AXIS;
            end
            S_AWAIT:
            begin
                scaled_reg <= q_c + 48'(frac_sel_c);
            end
            S_AFIX1:
            begin
                whole_reg <= scaled_reg[47] ? -whole_mag_c : whole_mag_c;
                fr_reg    <= scaled_reg[47] ? -frac_mag_c : frac_mag_c;
            end
            S_AFIX2:
            begin
                if (axis_reg)
                    gy_reg <= lim_c;
                else
                    gx_reg <= lim_c;
                axis_reg <= 1'b1;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_word_reg.report_x <= rx_c[7:0];
                    out_word_reg.report_y <= ry_c[7:0];
                end
            end
            default: ;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign pready    = 1'b1;

    `PMA_CHECK_NEXT(a_accept_starts, clk, rst_n, in_valid && in_ready, state_reg == S_PREP, "accepted word did not start processing")
    `PMA_CHECK(a_div_done_waited, clk, rst_n, div_done, state_reg == S_SPWAIT || state_reg == S_TWAIT || state_reg == S_SWAIT || state_reg == S_GWAIT || state_reg == S_AWAIT, "divider finished outside a wait state")
    `PMA_CHECK(a_root_done_waited, clk, rst_n, root_done, state_reg == S_RTWAIT, "root unit finished outside its wait state")
    `PMA_CHECK(a_report_in_limit, clk, rst_n, state_reg == S_OUT, gx_reg >= -LIM16 && gx_reg <= LIM16 && gy_reg >= -LIM16 && gy_reg <= LIM16, "axis result beyond report limit")

endmodule

>>> sv/pma_div.sv
// ----------------------------------------------------------------------------
// pma_div
// restoring divider, one quotient bit per cycle, shared by all divisions
// ----------------------------------------------------------------------------
module pma_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pma_pkg::DIV_NUM_W-1:0]  num,
    input  logic [pma_pkg::DIV_DEN_W-1:0]  den,
    input  logic [pma_pkg::DIV_CNT_W-1:0]  steps,
    output logic                           done,
    output logic [pma_pkg::DIV_NUM_W-1:0]  quot
);

    localparam int NW = pma_pkg::DIV_NUM_W;
    localparam int DW = pma_pkg::DIV_DEN_W;

    logic [NW-1:0]                 quo_reg, quo_next;
    logic [DW-1:0]                 rem_reg, rem_next;
    logic [DW-1:0]                 den_reg;
    logic [pma_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          done_reg;
    logic [DW:0]                   shifted;
    logic [DW:0]                   diff;
    logic                          fits;

    // numerator arrives left aligned so the quotient ends in the low bits
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NW-1]};
        fits     = shifted >= {1'b0, den_reg};
        diff     = shifted - {1'b0, den_reg};
        rem_next = fits ? diff[DW-1:0] : shifted[DW-1:0];
        quo_next = {quo_reg[NW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= steps;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == pma_pkg::DIV_CNT_W'(1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

>>> sv/pma_sqrt.sv
// ----------------------------------------------------------------------------
// pma_sqrt
// integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module pma_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] n,
    output logic        done,
    output logic [15:0] root
);

    logic [31:0] n_reg;
    logic [31:0] res_reg;
    logic [31:0] bit_reg;
    logic        done_reg;
    logic [31:0] trial;
    logic        ge;

    always_comb
    begin
        trial = res_reg + bit_reg;
        ge    = n_reg >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                bit_reg <= pma_pkg::ROOT_TOP;
            end
            else if (bit_reg != '0)
            begin
                bit_reg  <= bit_reg >> 2;
                done_reg <= (bit_reg == 32'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= n;
            res_reg <= '0;
        end
        else if (bit_reg != '0)
        begin
            if (ge)
            begin
                n_reg   <= n_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[15:0];

endmodule

>>> sv/pma_regs.sv
// ----------------------------------------------------------------------------
// pma_regs
// configuration registers behind the bus port
// ----------------------------------------------------------------------------
module pma_regs (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output pma_pkg::pma_cfg_t cfg,
    output logic              cpi_clear
);

    pma_pkg::pma_cfg_t cfg_reg;
    logic              wr;
    logic [2:0]        idx;
    logic [6:0]        cpi_in;
    logic [6:0]        cpi_fix;

    always_comb
    begin
        wr      = psel && penable && pwrite;
        idx     = paddr[4:2];
        cpi_in  = pwdata[6:0];
        if (cpi_in == 7'd0)
            cpi_fix = pma_pkg::CPI_DEFAULT;
        else if (cpi_in > pma_pkg::CPI_MAX)
            cpi_fix = pma_pkg::CPI_MAX;
        else
            cpi_fix = cpi_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cpi_hundreds      <= pma_pkg::CPI_DEFAULT;
            cfg_reg.accel_start_speed <= pma_pkg::START_DEFAULT;
            cfg_reg.accel_end_speed   <= pma_pkg::END_DEFAULT;
            cfg_reg.gain_min          <= pma_pkg::GMIN_DEFAULT;
            cfg_reg.gain_max          <= pma_pkg::GMAX_DEFAULT;
            cfg_reg.idle_reset_ms     <= pma_pkg::IDLE_DEFAULT;
            cfg_reg.left_side         <= 1'b0;
            cfg_reg.mounting          <= 1'b0;
        end
        else if (wr)
        begin
            unique case (idx)
                pma_pkg::REG_CPI:   cfg_reg.cpi_hundreds      <= cpi_fix;
                pma_pkg::REG_START: cfg_reg.accel_start_speed <= pwdata[23:0];
                pma_pkg::REG_END:   cfg_reg.accel_end_speed   <= pwdata[23:0];
                pma_pkg::REG_GMIN:  cfg_reg.gain_min          <= pwdata[9:0];
                pma_pkg::REG_GMAX:  cfg_reg.gain_max          <= pwdata[9:0];
                pma_pkg::REG_IDLE:  cfg_reg.idle_reset_ms     <= pwdata[15:0];
                pma_pkg::REG_LEFT:  cfg_reg.left_side         <= pwdata[0];
                pma_pkg::REG_MOUNT: cfg_reg.mounting          <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            pma_pkg::REG_CPI:   prdata = {25'd0, cfg_reg.cpi_hundreds};
            pma_pkg::REG_START: prdata = {8'd0, cfg_reg.accel_start_speed};
            pma_pkg::REG_END:   prdata = {8'd0, cfg_reg.accel_end_speed};
            pma_pkg::REG_GMIN:  prdata = {22'd0, cfg_reg.gain_min};
            pma_pkg::REG_GMAX:  prdata = {22'd0, cfg_reg.gain_max};
            pma_pkg::REG_IDLE:  prdata = {16'd0, cfg_reg.idle_reset_ms};
            pma_pkg::REG_LEFT:  prdata = {31'd0, cfg_reg.left_side};
            pma_pkg::REG_MOUNT: prdata = {31'd0, cfg_reg.mounting};
            default:            prdata = '0;
        endcase
    end

    assign cfg       = cfg_reg;
    assign cpi_clear = wr && (idx == pma_pkg::REG_CPI);

endmodule

>>> bench/tb_pointer_motion_acceleration.sv
// ----------------------------------------------------------------------------
// tb_pointer_motion_acceleration
// random and directed sensor words checked against a built-in predictor of
// speed, gain, remainder and mounting behavior, across several register sets
// ----------------------------------------------------------------------------
module tb_pointer_motion_acceleration;
    import pma_pkg::*;

    localparam int LIMIT = 127;
    localparam int FIRST_MS = 8;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    pma_in_t     in_word;
    logic        out_valid;
    logic        out_ready;
    pma_out_t    out_word;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pointer_motion_acceleration uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // predictor state
    pma_cfg_t    cfg;
    int          frac_x, frac_y;
    int unsigned speed_avg, prev_time;
    int          sign_x, sign_y;

    pma_in_t     pending_words[$];
    pma_out_t    expected_reports[$];
    int          mismatches;
    bit          stim_done;
    bit          sender_hold;
    int unsigned time_now;

    function automatic int sgn(int v);
        return v < 0 ? -1 : (v > 0 ? 1 : 0);
    endfunction

    function automatic longint clamp_lim(longint v);
        if (v < -LIMIT) return -LIMIT;
        if (v > LIMIT) return LIMIT;
        return v;
    endfunction

    function automatic int unsigned isqrt(int unsigned n);
        int unsigned r, b;
        r = 0;
        b = 32'h4000_0000;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint gain_at(int unsigned spd);
        longint unsigned t, s;
        longint span;
        if (spd <= cfg.accel_start_speed) return longint'(cfg.gain_min);
        if (spd >= cfg.accel_end_speed) return longint'(cfg.gain_max);
        t = (longint'(spd - cfg.accel_start_speed) * 1000) /
            longint'(cfg.accel_end_speed - cfg.accel_start_speed);
        s = t * t * (3000 - 2 * t) / 1000000;
        span = longint'(cfg.gain_max) - longint'(cfg.gain_min);
        return longint'(cfg.gain_min) + (span * longint'(s)) / 1000;
    endfunction

    function automatic int scale_axis(int v, longint g, ref int frac);
        longint sc, whole, kept, lim;
        sc = (longint'(v) * g * 65536) / 100 + longint'(frac);
        whole = sc / 65536;
        frac = int'(sc - whole * 65536);
        lim = clamp_lim(whole);
        if (lim != whole)
        begin
            kept = longint'(frac) + (whole - lim) * 65536;
            if (kept < -64'sd2147483648) kept = -64'sd2147483648;
            if (kept > 64'sd2147483647) kept = 64'sd2147483647;
            frac = int'(kept);
        end
        return int'(lim);
    endfunction

    function automatic void clear_motion();
        frac_x = 0;
        frac_y = 0;
        speed_avg = 0;
        prev_time = 0;
        sign_x = 0;
        sign_y = 0;
    endfunction

    function automatic pma_out_t predict_report(pma_in_t w);
        int x, y, sx, sy, gx, gy, rx, ry;
        int unsigned el, mag, spd;
        bit flip;
        longint g;
        pma_out_t r;
        x = w.delta_x;
        y = w.delta_y;
        gx = 0;
        gy = 0;
        el = (prev_time == 0) ? FIRST_MS : w.time_ms - prev_time;
        prev_time = w.time_ms;
        if (el == 0) el = 1;
        if (el >= cfg.idle_reset_ms)
        begin
            speed_avg = 0;
            frac_x = 0;
            frac_y = 0;
            sign_x = 0;
            sign_y = 0;
        end
        if (x != 0 || y != 0)
        begin
            sx = sgn(x);
            sy = sgn(y);
            flip = (sx != 0 && sign_x != 0 && sx != sign_x) ||
                   (sy != 0 && sign_y != 0 && sy != sign_y);
            if (flip)
            begin
                speed_avg = 0;
                if (sx != 0 && sx != sign_x) frac_x = 0;
                if (sy != 0 && sy != sign_y) frac_y = 0;
            end
            if (sx != 0) sign_x = sx;
            if (sy != 0) sign_y = sy;
            mag = isqrt(int'(x * x + y * y));
            spd = int'((longint'(mag) * 100000) /
                       (longint'(cfg.cpi_hundreds) * 100 * longint'(el)));
            if (speed_avg == 0 || flip)
                speed_avg = spd;
            else
                speed_avg = int'((longint'(speed_avg) + longint'(spd)) / 2);
            g = gain_at(speed_avg);
            gx = scale_axis(x, g, frac_x);
            gy = scale_axis(y, g, frac_y);
        end
        if (cfg.mounting == 1'b0)
        begin
            rx = int'(clamp_lim(gy));
            ry = int'(clamp_lim(gx));
            if (cfg.left_side)
            begin
                rx = -rx;
                ry = -ry;
            end
        end
        else
        begin
            rx = int'(clamp_lim(gx));
            ry = -int'(clamp_lim(gy));
        end
        r.report_x = rx[7:0];
        r.report_y = ry[7:0];
        return r;
    endfunction

    // driver
    int send_wait;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word <= '0;
            send_wait <= 0;
        end
        else if (in_valid && !in_ready)
        begin
        end
        else if (send_wait > 0)
        begin
            in_valid <= 1'b0;
            send_wait <= send_wait - 1;
        end
        else if (pending_words.size() > 0 && !sender_hold)
        begin
            in_word <= pending_words[0];
            expected_reports.push_back(predict_report(pending_words.pop_front()));
            in_valid <= 1'b1;
            send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        end
        else
            in_valid <= 1'b0;
    end

    // monitor
    int recv_wait;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected report x=%0d y=%0d",
                                 out_word.report_x, out_word.report_y);
                end
                else
                begin
                    pma_out_t e;
                    e = expected_reports.pop_front();
                    if (e.report_x !== out_word.report_x ||
                        e.report_y !== out_word.report_y)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("report mismatch: expected %0d,%0d got %0d,%0d",
                                     e.report_x, e.report_y,
                                     out_word.report_x, out_word.report_y);
                    end
                end
            end
            if (recv_wait > 0)
            begin
                out_ready <= 1'b0;
                recv_wait <= recv_wait - 1;
            end
            else if (out_valid && out_ready)
            begin
                recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic wait_idle();
        while (pending_words.size() > 0 || expected_reports.size() > 0 || in_valid)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CPI:
            begin
                cfg.cpi_hundreds = (val[6:0] == 0) ? CPI_DEFAULT :
                                   (val[6:0] > CPI_MAX) ? CPI_MAX : val[6:0];
                clear_motion();
            end
            REG_START: cfg.accel_start_speed = val[23:0];
            REG_END:   cfg.accel_end_speed = val[23:0];
            REG_GMIN:  cfg.gain_min = val[9:0];
            REG_GMAX:  cfg.gain_max = val[9:0];
            REG_IDLE:  cfg.idle_reset_ms = val[15:0];
            REG_LEFT:  cfg.left_side = val[0];
            REG_MOUNT: cfg.mounting = val[0];
            default: ;
        endcase
    endtask

    task automatic push_word(int dx, int dy, int unsigned step);
        pma_in_t w;
        time_now = time_now + step;
        w.delta_x = dx[15:0];
        w.delta_y = dy[15:0];
        w.time_ms = time_now;
        pending_words.push_back(w);
    endtask

    task automatic random_phase(int n);
        int dx, dy, k;
        int unsigned step;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 9);
            if (k < 6)
            begin
                dx = $urandom_range(0, 60) - 30;
                dy = $urandom_range(0, 60) - 30;
            end
            else if (k < 8)
            begin
                dx = $urandom_range(0, 800) - 400;
                dy = $urandom_range(0, 800) - 400;
            end
            else
            begin
                dx = $signed($urandom_range(0, 65535)) - 32768;
                dy = $signed($urandom_range(0, 65535)) - 32768;
            end
            k = $urandom_range(0, 19);
            step = (k == 0) ? $urandom : (k < 3) ? 0 : (k < 5) ? $urandom_range(50, 300)
                 : $urandom_range(1, 20);
            push_word(dx, dy, step);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        mismatches = 0;
        stim_done = 0;
        sender_hold = 0;
        time_now = 0;
        cfg.cpi_hundreds = CPI_DEFAULT;
        cfg.accel_start_speed = START_DEFAULT;
        cfg.accel_end_speed = END_DEFAULT;
        cfg.gain_min = GMIN_DEFAULT;
        cfg.gain_max = GMAX_DEFAULT;
        cfg.idle_reset_ms = IDLE_DEFAULT;
        cfg.left_side = 1'b0;
        cfg.mounting = 1'b0;
        clear_motion();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: first motion at time 0, zero interval, extremes, reversal
        push_word(0, 0, 0);
        push_word(5, 3, 0);
        push_word(5, 3, 0);
        push_word(32767, -32768, 4);
        push_word(-32768, 32767, 4);
        push_word(-10, -10, 2);
        push_word(12, 0, 2);
        push_word(0, 0, 500);
        push_word(1, -1, 1);
        push_word(-1, 1, 1);
        wait_idle();

        reg_write(REG_CPI, 0);
        reg_write(REG_START, 0);
        reg_write(REG_END, 24'hFFFFFF);
        reg_write(REG_GMIN, 0);
        reg_write(REG_GMAX, 1000);
        reg_write(REG_IDLE, 16'hFFFF);
        reg_write(REG_LEFT, 1);
        reg_write(REG_MOUNT, 0);
        push_word(300, -200, 3);
        push_word(32767, 32767, 1);
        push_word(-3, 7, 1);
        push_word(100, 100, 2);
        push_word(-32768, -32768, 5);
        wait_idle();

        reg_write(REG_CPI, 127);
        reg_write(REG_START, 50);
        reg_write(REG_END, 2000);
        reg_write(REG_GMIN, 50);
        reg_write(REG_GMAX, 400);
        reg_write(REG_MOUNT, 1);
        random_phase(400);
        wait_idle();

        reg_write(REG_CPI, 1);
        reg_write(REG_START, 24'hFFFFFF);
        reg_write(REG_END, 1);
        reg_write(REG_GMIN, 1000);
        reg_write(REG_GMAX, 0);
        reg_write(REG_IDLE, 0);
        reg_write(REG_LEFT, 0);
        reg_write(REG_MOUNT, 0);
        random_phase(200);
        // let everything drain before more words go in
        sender_hold = 1;
        random_phase(100);
        while (expected_reports.size() > 0 || in_valid) @(posedge clk);
        sender_hold = 0;
        wait_idle();

        reg_write(REG_CPI, 8);
        reg_write(REG_START, 200);
        reg_write(REG_END, 3000);
        reg_write(REG_GMIN, 800);
        reg_write(REG_GMAX, 100);
        reg_write(REG_IDLE, 40);
        reg_write(REG_LEFT, 1);
        random_phase(500);
        wait_idle();

        reg_write(REG_CPI, 120);
        reg_write(REG_START, 10);
        reg_write(REG_END, 500);
        reg_write(REG_GMIN, 100);
        reg_write(REG_GMAX, 1000);
        reg_write(REG_IDLE, 1000);
        reg_write(REG_MOUNT, 1);
        random_phase(730);
        wait_idle();

        stim_done = 1;
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/pma_pkg.sv
sv/pma_div.sv
sv/pma_sqrt.sv
sv/pma_regs.sv
sv/pointer_motion_acceleration.sv
bench/tb_pointer_motion_acceleration.sv
